// File: sv/bmprgb_pkg.sv
// Shared types and constants for the BMP to RGB222 pixel converter.
`timescale 1ns / 1ps

package bmprgb_pkg;

  localparam int unsigned ADDR_W     = 20;
  localparam int unsigned DIM_OUT_W  = 11;
  localparam int unsigned COLOR_W    = 6;
  localparam int unsigned HDR_IDX_W  = 6;

  // Header layout and the values the checks expect.
  localparam logic [HDR_IDX_W-1:0] IDX_SIG_HI    = 6'd0;
  localparam logic [HDR_IDX_W-1:0] IDX_SIG_LO    = 6'd1;
  localparam logic [HDR_IDX_W-1:0] IDX_OFFSET    = 6'd10;
  localparam logic [HDR_IDX_W-1:0] IDX_INFO_SIZE = 6'd14;
  localparam logic [HDR_IDX_W-1:0] IDX_WIDTH     = 6'd18;
  localparam logic [HDR_IDX_W-1:0] IDX_HEIGHT    = 6'd22;
  localparam logic [HDR_IDX_W-1:0] IDX_PLANES    = 6'd26;
  localparam logic [HDR_IDX_W-1:0] IDX_COMPRESS  = 6'd30;
  localparam logic [HDR_IDX_W-1:0] IDX_HDR_LAST  = 6'd53;

  localparam logic [15:0] SIGNATURE     = 16'h424D;
  localparam logic [7:0]  PIXEL_OFFSET  = 8'd54;
  localparam logic [7:0]  INFO_HDR_SIZE = 8'd40;
  localparam logic [7:0]  PLANE_COUNT   = 8'd1;
  localparam logic [7:0]  NO_COMPRESS   = 8'd0;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_HEADER = 2'd1,
    MODE_PIXELS = 2'd2,
    MODE_DONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HDR_OK = 2'd1,
    KIND_HDR_BAD = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_SIGNATURE = 3'd1,
    ERR_HDR_SIZE  = 3'd2,
    ERR_PLANES    = 3'd3,
    ERR_COMPRESS  = 3'd4,
    ERR_DIMENSION = 3'd5
  } err_t;

  typedef enum logic [1:0] {
    PHASE_BLUE  = 2'd0,
    PHASE_GREEN = 2'd1,
    PHASE_RED   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0]           result_kind;
    logic [2:0]           error_code;
    logic [COLOR_W-1:0]   pixel_color;
    logic [ADDR_W-1:0]    pixel_address;
    logic [DIM_OUT_W-1:0] image_width;
    logic [DIM_OUT_W-1:0] image_height;
    logic                 last_pixel;
  } result_t;

endpackage

// File: sv/bmprgb_if.sv
// Stream interfaces for the byte input and the result output channels.
`timescale 1ns / 1ps

interface bmprgb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface bmprgb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [2:0]  error_code;
  logic [5:0]  pixel_color;
  logic [19:0] pixel_address;
  logic [10:0] image_width;
  logic [10:0] image_height;
  logic        last_pixel;

  modport source (output valid, output result_kind, output error_code, output pixel_color,
                  output pixel_address, output image_width, output image_height,
                  output last_pixel, input ready);
  modport sink   (input valid, input result_kind, input error_code, input pixel_color,
                  input pixel_address, input image_width, input image_height,
                  input last_pixel, output ready);
endinterface

// File: sv/bmprgb_parser.sv
// Header checker and pixel packer: all parse state, one byte per step.
`timescale 1ns / 1ps

module bmprgb_parser #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                start_of_file,
  output logic                res_valid,
  output bmprgb_pkg::result_t res
);
  import bmprgb_pkg::*;

  localparam int unsigned WD_W   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HT_W   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PROD_W = WD_W + HT_W;

  mode_t                mode_r, mode_nxt;
  logic [HDR_IDX_W-1:0] idx_r, idx_nxt;
  err_t                 err_r, err_nxt;
  logic [7:0]           sig_hi_r, sig_hi_nxt;
  logic [31:0]          width_r, width_nxt;
  logic [31:0]          height_r, height_nxt;
  phase_t               phase_r, phase_nxt;
  logic [3:0]           held_r, held_nxt;
  logic [WD_W-1:0]      col_r, col_nxt;
  logic [HT_W-1:0]      rows_r, rows_nxt;
  logic [1:0]           pad_r, pad_nxt;
  logic [ADDR_W-1:0]    waddr_r, waddr_nxt;
  logic [ADDR_W-1:0]    row_base_r, row_base_nxt;
  logic [ADDR_W-1:0]    first_base_r, first_base_nxt;

  logic [1:0]           top_bits;
  logic [HDR_IDX_W-1:0] w_ofs, h_ofs;
  logic                 in_width_field, in_height_field;
  logic [HT_W-1:0]      height_m1;
  logic [PROD_W-1:0]    prod;
  logic                 dims_too_big, dims_zero;
  err_t                 final_err;
  logic [WD_W-1:0]      col_inc;
  logic                 row_end;
  logic [ADDR_W-1:0]    width_addr;

  assign top_bits        = data_byte[7:6];
  assign w_ofs           = idx_r - IDX_WIDTH;
  assign h_ofs           = idx_r - IDX_HEIGHT;
  assign in_width_field  = (idx_r >= IDX_WIDTH) && (idx_r < IDX_HEIGHT);
  assign in_height_field = (idx_r >= IDX_HEIGHT) && (idx_r < IDX_PLANES);

  // Base of the bottom file row in the top-down buffer, (height - 1) * width.
  // Taken while the planes byte passes, once both words are complete.
  assign height_m1 = height_r[HT_W-1:0] - HT_W'(1);
  assign prod      = {{WD_W{1'b0}}, height_m1} * {{HT_W{1'b0}}, width_r[WD_W-1:0]};

  assign dims_too_big = (width_r > 32'(MAX_WIDTH)) || (height_r > 32'(MAX_HEIGHT));
  assign dims_zero    = (width_r == 32'd0) || (height_r == 32'd0);
  assign final_err    = (err_r == ERR_NONE && dims_too_big) ? ERR_DIMENSION : err_r;

  assign col_inc    = col_r + WD_W'(1);
  assign row_end    = (col_inc == width_r[WD_W-1:0]);
  assign width_addr = ADDR_W'(width_r[WD_W-1:0]);

  // Next state.
  always_comb begin
    mode_nxt       = mode_r;
    idx_nxt        = idx_r;
    err_nxt        = err_r;
    sig_hi_nxt     = sig_hi_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    phase_nxt      = phase_r;
    held_nxt       = held_r;
    col_nxt        = col_r;
    rows_nxt       = rows_r;
    pad_nxt        = pad_r;
    waddr_nxt      = waddr_r;
    row_base_nxt   = row_base_r;
    first_base_nxt = first_base_r;
    if (start_of_file) begin
      // A start mark clears the header, error and pixel state and the byte is header byte 0.
      mode_nxt   = MODE_HEADER;
      idx_nxt    = IDX_SIG_LO;
      err_nxt    = ERR_NONE;
      sig_hi_nxt = data_byte;
      width_nxt  = '0;
      height_nxt = '0;
      phase_nxt  = PHASE_BLUE;
      held_nxt   = '0;
      col_nxt    = '0;
      rows_nxt   = '0;
      pad_nxt    = '0;
      waddr_nxt  = '0;
    end else begin
      case (mode_r)
        MODE_HEADER: begin
          idx_nxt = idx_r + HDR_IDX_W'(1);
          if (idx_r == IDX_SIG_HI) begin
            sig_hi_nxt = data_byte;
          end else if (idx_r == IDX_SIG_LO) begin
            if ({sig_hi_r, data_byte} != SIGNATURE && err_r == ERR_NONE) begin
              err_nxt = ERR_SIGNATURE;
            end
          end else if (idx_r == IDX_OFFSET) begin
            if (data_byte != PIXEL_OFFSET && err_r == ERR_NONE) begin
              err_nxt = ERR_HDR_SIZE;
            end
          end else if (idx_r == IDX_INFO_SIZE) begin
            if (data_byte != INFO_HDR_SIZE && err_r == ERR_NONE) begin
              err_nxt = ERR_HDR_SIZE;
            end
          end else if (idx_r == IDX_PLANES) begin
            if (data_byte != PLANE_COUNT && err_r == ERR_NONE) begin
              err_nxt = ERR_PLANES;
            end
            first_base_nxt = ADDR_W'(prod);
          end else if (idx_r == IDX_COMPRESS) begin
            if (data_byte != NO_COMPRESS && err_r == ERR_NONE) begin
              err_nxt = ERR_COMPRESS;
            end
          end else if (in_width_field) begin
            width_nxt[{w_ofs[1:0], 3'b000} +: 8] = data_byte;
          end else if (in_height_field) begin
            height_nxt[{h_ofs[1:0], 3'b000} +: 8] = data_byte;
          end
          if (idx_r == IDX_HDR_LAST) begin
            err_nxt = final_err;
            if (final_err != ERR_NONE || dims_zero) begin
              mode_nxt = MODE_DONE;
            end else begin
              mode_nxt     = MODE_PIXELS;
              rows_nxt     = height_r[HT_W-1:0];
              col_nxt      = '0;
              phase_nxt    = PHASE_BLUE;
              pad_nxt      = '0;
              waddr_nxt    = first_base_r;
              row_base_nxt = first_base_r;
            end
          end
        end
        MODE_PIXELS: begin
          if (pad_r != 2'd0) begin
            pad_nxt = pad_r - 2'd1;
          end else begin
            case (phase_r)
              PHASE_BLUE: begin
                held_nxt[1:0] = top_bits;
                phase_nxt     = PHASE_GREEN;
              end
              PHASE_GREEN: begin
                held_nxt[3:2] = top_bits;
                phase_nxt     = PHASE_RED;
              end
              default: begin
                phase_nxt = PHASE_BLUE;
                if (row_end) begin
                  col_nxt = '0;
                  pad_nxt = width_r[1:0];
                  if (rows_r <= HT_W'(1)) begin
                    rows_nxt = '0;
                    mode_nxt = MODE_DONE;
                  end else begin
                    rows_nxt     = rows_r - HT_W'(1);
                    row_base_nxt = row_base_r - width_addr;
                    waddr_nxt    = row_base_r - width_addr;
                  end
                end else begin
                  col_nxt   = col_inc;
                  waddr_nxt = waddr_r + ADDR_W'(1);
                end
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result for the byte being taken.
  always_comb begin
    res_valid         = 1'b0;
    res.result_kind   = KIND_PIXEL;
    res.error_code    = ERR_NONE;
    res.pixel_color   = '0;
    res.pixel_address = '0;
    res.image_width   = width_r[DIM_OUT_W-1:0];
    res.image_height  = height_r[DIM_OUT_W-1:0];
    res.last_pixel    = 1'b0;
    if (step && !start_of_file) begin
      case (mode_r)
        MODE_HEADER: begin
          if (idx_r == IDX_HDR_LAST) begin
            res_valid = 1'b1;
            if (final_err != ERR_NONE) begin
              res.result_kind = KIND_HDR_BAD;
              res.error_code  = final_err;
            end else begin
              res.result_kind = KIND_HDR_OK;
            end
          end
        end
        MODE_PIXELS: begin
          if (pad_r == 2'd0 && phase_r == PHASE_RED) begin
            res_valid         = 1'b1;
            res.pixel_color   = {top_bits, held_r};
            res.pixel_address = waddr_r;
            res.last_pixel    = row_end && (rows_r <= HT_W'(1));
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
    end else if (step) begin
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      idx_r        <= idx_nxt;
      err_r        <= err_nxt;
      sig_hi_r     <= sig_hi_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      phase_r      <= phase_nxt;
      held_r       <= held_nxt;
      col_r        <= col_nxt;
      rows_r       <= rows_nxt;
      pad_r        <= pad_nxt;
      waddr_r      <= waddr_nxt;
      row_base_r   <= row_base_nxt;
      first_base_r <= first_base_nxt;
    end
  end

  a_pixels_have_size: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_PIXELS |-> width_r != 32'd0 && rows_r != '0)
    else $error("pixel mode entered with an empty image");

  a_column_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_PIXELS |-> col_r < width_r[WD_W-1:0])
    else $error("column count ran past the row width");

  a_result_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> step)
    else $error("result raised without an accepted byte");

endmodule

// File: sv/bmprgb_obuf.sv
// Two-entry output buffer: result register plus skid entry.
`timescale 1ns / 1ps

module bmprgb_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bmprgb_pkg::result_t push_data,
  output logic                space,
  output logic                out_valid,
  input  logic                out_ready,
  output bmprgb_pkg::result_t out_data
);
  import bmprgb_pkg::*;

  logic    main_v_r, main_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop       = main_v_r && out_ready;
  assign space     = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    main_nxt   = main_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (!main_v_r || pop) begin
      if (skid_v_r) begin
        main_v_nxt = 1'b1;
        main_nxt   = skid_r;
        skid_v_nxt = push;
        skid_nxt   = push_data;
      end else begin
        main_v_nxt = push;
        main_nxt   = push_data;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_v_r)
    else $error("result pushed while both entries are full");

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry holds a word ahead of an empty main entry");

  a_stalled_push_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    main_v_r && !out_ready && push |=> skid_v_r && main_v_r)
    else $error("word pushed during a stall was not kept");

endmodule

// File: sv/bmp_stream_to_rgb222_pixels_core.sv
// Top level of the BMP byte stream to RGB222 pixel converter.
`timescale 1ns / 1ps

// Channel   Direction  Word                                   Handshake
// in_bus    in         data_byte, start_of_file               valid/ready
// out_bus   out        kind, error, colour, address, dims,    valid/ready
//                      last_pixel
//
// One byte is taken per cycle while the output buffer has space. Every
// accepted byte updates the parse state at that edge, and a result, if any,
// is registered at the same edge, behind any older word still buffered.
// The result register is followed by a skid entry, so a stall on out_bus
// stops in_bus only once both entries are full.
// Reset (rst_n low, synchronous) leaves the parser idle, ignoring bytes
// until one arrives with start_of_file set.

module bmp_stream_to_rgb222_pixels_core #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  bmprgb_in_if.sink           in_bus,
  bmprgb_out_if.source        out_bus
);
  import bmprgb_pkg::*;

  logic    step;
  logic    res_valid;
  result_t res;
  logic    space;
  result_t out_data;

  // A byte is taken whenever the output buffer can absorb one more word,
  // whether or not this particular byte produces one.
  assign in_bus.ready = space;
  assign step         = in_bus.valid && space;

  // The parser holds the header checks, the captured width and height, the
  // colour packing of each blue, green, red triple and the row-flipped write
  // address. The first row base, (height - 1) * width, is multiplied out
  // while the header is still streaming, so the end of the header only
  // copies it; later rows step down by one width with a subtraction.
  bmprgb_parser #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .data_byte     (in_bus.data_byte),
    .start_of_file (in_bus.start_of_file),
    .res_valid     (res_valid),
    .res           (res)
  );

  bmprgb_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_data  (out_data)
  );

  assign out_bus.result_kind   = out_data.result_kind;
  assign out_bus.error_code    = out_data.error_code;
  assign out_bus.pixel_color   = out_data.pixel_color;
  assign out_bus.pixel_address = out_data.pixel_address;
  assign out_bus.image_width   = out_data.image_width;
  assign out_bus.image_height  = out_data.image_height;
  assign out_bus.last_pixel    = out_data.last_pixel;

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the BMP byte stream to RGB222 pixel converter.
`timescale 1ns / 1ps

module tb_top;
  import bmprgb_pkg::*;

  localparam int unsigned MAX_W        = 1024;
  localparam int unsigned MAX_H        = 1024;
  localparam int unsigned HDR_LEN      = int'(IDX_HDR_LAST) + 1;
  localparam int unsigned RANDOM_BYTES = 120;
  // Longest quiet spell is one long stall on either side plus the skid entries.
  localparam int unsigned IDLE_LIMIT   = 1000;
  // A stalled receiver can sit on the last words for a long gap before taking them.
  localparam int unsigned DRAIN_CYCLES = 80;

  // Predicts the result words from the accepted bytes and checks what the block sends.
  class rgb222_scoreboard;
    int unsigned max_w;
    int unsigned max_h;
    mode_t       mode;
    int unsigned hdr_idx;
    err_t        first_err;
    logic [7:0]  sig_hi;
    logic [31:0] width_w;
    logic [31:0] height_w;
    phase_t      phase;
    logic [3:0]  held_bg;
    logic [31:0] col_count;
    logic [31:0] rows_left;
    logic [1:0]  pad_left;
    logic [19:0] next_addr;
    result_t     pending_results[$];
    int unsigned mismatches;

    function new(int unsigned mw, int unsigned mh);
      max_w      = mw;
      max_h      = mh;
      mismatches = 0;
      mode       = MODE_IDLE;
      clear_file();
    endfunction

    function void clear_file();
      hdr_idx   = 0;
      first_err = ERR_NONE;
      sig_hi    = '0;
      width_w   = '0;
      height_w  = '0;
      phase     = PHASE_BLUE;
      held_bg   = '0;
      col_count = '0;
      rows_left = '0;
      pad_left  = '0;
      next_addr = '0;
    endfunction

    function void flag(err_t code);
      if (first_err == ERR_NONE) first_err = code;
    endfunction

    function void expect_result(result_t r);
      pending_results.insert(pending_results.size(), r);
    endfunction

    // Rows arrive bottom-up, so row n-1 of the file lands at the top of the buffer.
    function logic [19:0] row_base(logic [31:0] rows);
      logic [63:0] prod;
      prod = 64'(rows - 32'd1) * 64'(width_w);
      return prod[19:0];
    endfunction

    function result_t make_result(kind_t kind, err_t err, logic [5:0] color,
                                  logic [19:0] addr, logic last);
      result_t r;
      r.result_kind   = kind;
      r.error_code    = err;
      r.pixel_color   = color;
      r.pixel_address = addr;
      r.image_width   = width_w[10:0];
      r.image_height  = height_w[10:0];
      r.last_pixel    = last;
      return r;
    endfunction

    function void take_header_byte(logic [7:0] b);
      int unsigned i;
      i = hdr_idx;
      if (i == IDX_SIG_HI) begin
        sig_hi = b;
      end else if (i == IDX_SIG_LO) begin
        if ({sig_hi, b} != SIGNATURE) flag(ERR_SIGNATURE);
      end else if (i == IDX_OFFSET) begin
        if (b != PIXEL_OFFSET) flag(ERR_HDR_SIZE);
      end else if (i == IDX_INFO_SIZE) begin
        if (b != INFO_HDR_SIZE) flag(ERR_HDR_SIZE);
      end else if (i == IDX_PLANES) begin
        if (b != PLANE_COUNT) flag(ERR_PLANES);
      end else if (i == IDX_COMPRESS) begin
        if (b != NO_COMPRESS) flag(ERR_COMPRESS);
      end else if (i >= IDX_WIDTH && i < IDX_WIDTH + 4) begin
        width_w |= 32'(b) << (8 * (i - IDX_WIDTH));
      end else if (i >= IDX_HEIGHT && i < IDX_HEIGHT + 4) begin
        height_w |= 32'(b) << (8 * (i - IDX_HEIGHT));
      end
      hdr_idx = i + 1;
      if (hdr_idx <= IDX_HDR_LAST) return;

      // The size check only counts when every field check has passed.
      if (first_err == ERR_NONE && (width_w > max_w || height_w > max_h))
        first_err = ERR_DIMENSION;
      if (first_err != ERR_NONE) begin
        mode = MODE_DONE;
        expect_result(make_result(KIND_HDR_BAD, first_err, '0, '0, 1'b0));
        return;
      end
      if (width_w == 0 || height_w == 0) begin
        mode = MODE_DONE;
      end else begin
        mode      = MODE_PIXELS;
        rows_left = height_w;
        col_count = '0;
        phase     = PHASE_BLUE;
        pad_left  = '0;
        next_addr = row_base(rows_left);
      end
      expect_result(make_result(KIND_HDR_OK, ERR_NONE, '0, '0, 1'b0));
    endfunction

    function void take_pixel_byte(logic [7:0] b);
      logic [19:0] addr;
      logic        last;
      if (pad_left != 0) begin
        pad_left = pad_left - 2'd1;
        return;
      end
      case (phase)
        PHASE_BLUE: begin
          held_bg = {2'b00, b[7:6]};
          phase   = PHASE_GREEN;
          return;
        end
        PHASE_GREEN: begin
          held_bg[3:2] = b[7:6];
          phase        = PHASE_RED;
          return;
        end
        default: begin
          phase = PHASE_BLUE;
        end
      endcase
      addr      = next_addr;
      last      = 1'b0;
      col_count = col_count + 1;
      if (col_count >= width_w) begin
        col_count = '0;
        pad_left  = width_w[1:0];
        if (rows_left <= 1) begin
          last      = 1'b1;
          rows_left = '0;
          mode      = MODE_DONE;
        end else begin
          rows_left = rows_left - 1;
          next_addr = row_base(rows_left);
        end
      end else begin
        next_addr = next_addr + 20'd1;
      end
      expect_result(make_result(KIND_PIXEL, ERR_NONE, {b[7:6], held_bg}, addr, last));
    endfunction

    function void note_byte(logic [7:0] b, logic sof);
      if (sof) begin
        clear_file();
        mode = MODE_HEADER;
      end
      if (mode == MODE_HEADER) take_header_byte(b);
      else if (mode == MODE_PIXELS) take_pixel_byte(b);
    endfunction

    task report(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task compare_field(string name, logic [31:0] seen, logic [31:0] wanted);
      if (seen !== wanted)
        report($sformatf("%s is %0h, expected %0h", name, seen, wanted));
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result kind %0d address %0h with nothing pending",
                         got.result_kind, got.pixel_address));
        return;
      end
      want = pending_results.pop_front();
      compare_field("result_kind", 32'(got.result_kind), 32'(want.result_kind));
      compare_field("error_code", 32'(got.error_code), 32'(want.error_code));
      compare_field("pixel_color", 32'(got.pixel_color), 32'(want.pixel_color));
      compare_field("pixel_address", 32'(got.pixel_address), 32'(want.pixel_address));
      compare_field("image_width", 32'(got.image_width), 32'(want.image_width));
      compare_field("image_height", 32'(got.image_height), 32'(want.image_height));
      compare_field("last_pixel", 32'(got.last_pixel), 32'(want.last_pixel));
    endtask
  endclass

  typedef struct packed {
    logic       sof;
    logic [7:0] data;
  } file_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  bmprgb_in_if  in_bus ();
  bmprgb_out_if out_bus ();

  bmp_stream_to_rgb222_pixels_core #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  rgb222_scoreboard sb;
  file_byte_t       file_bytes[$];
  int unsigned      counted_bytes = 0;
  int unsigned      idle_cycles = 0;
  int unsigned      stall_left = 0;
  bit               quiet_in = 1'b0;
  bit               quiet_out = 1'b0;
  result_t          seen_result;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Most gaps are short, a few are long, and in a quiet stretch there are none.
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Bytes taken up by the pixel rows, padding included, for an image that fits.
  function automatic int body_bytes(input logic [31:0] w, input logic [31:0] h);
    if (w > MAX_W || h > MAX_H) return 0;
    return int'(h) * (3 * int'(w) + int'(w[1:0]));
  endfunction

  // Appends one byte to the list waiting to be sent.
  task automatic queue_byte(input logic sof, input logic [7:0] data);
    file_byte_t fb;
    fb.sof  = sof;
    fb.data = data;
    file_bytes.insert(file_bytes.size(), fb);
  endtask

  // Bytes with no start mark, which the parser ignores while idle or finished.
  task automatic add_noise(input int count);
    for (int k = 0; k < count; k++)
      queue_byte(1'b0, 8'($urandom_range(0, 255)));
  endtask

  // Builds one file: a header with random filler around the checked fields, the
  // requested faults spoiled in, then the pixel rows.  A non-negative keep cuts
  // the file short so that the next start mark lands in the middle of it.
  task automatic add_file(input logic [31:0] w, input logic [31:0] h,
                          input logic [7:0] faults, input int keep,
                          input int tail, input int fill);
    logic [7:0] hdr [HDR_LEN];
    logic [7:0] v;
    int         idx;
    int         total;
    for (int k = 0; k < HDR_LEN; k++) hdr[k] = 8'($urandom_range(0, 255));
    // Only the low byte of each checked field matters; the upper bytes stay random.
    hdr[IDX_SIG_HI]    = SIGNATURE[15:8];
    hdr[IDX_SIG_LO]    = SIGNATURE[7:0];
    hdr[IDX_OFFSET]    = PIXEL_OFFSET;
    hdr[IDX_INFO_SIZE] = INFO_HDR_SIZE;
    hdr[IDX_PLANES]    = PLANE_COUNT;
    hdr[IDX_COMPRESS]  = NO_COMPRESS;
    for (int k = 0; k < 4; k++) begin
      hdr[IDX_WIDTH + k]  = w[8*k +: 8];
      hdr[IDX_HEIGHT + k] = h[8*k +: 8];
    end
    if (faults[ERR_SIGNATURE]) begin
      idx = ($urandom_range(0, 1) == 0) ? int'(IDX_SIG_HI) : int'(IDX_SIG_LO);
      hdr[idx] ^= 8'($urandom_range(1, 255));
    end
    if (faults[ERR_HDR_SIZE]) begin
      idx = ($urandom_range(0, 1) == 0) ? int'(IDX_OFFSET) : int'(IDX_INFO_SIZE);
      hdr[idx] ^= 8'($urandom_range(1, 255));
    end
    if (faults[ERR_PLANES])   hdr[IDX_PLANES]   ^= 8'($urandom_range(1, 255));
    if (faults[ERR_COMPRESS]) hdr[IDX_COMPRESS] ^= 8'($urandom_range(1, 255));

    total = HDR_LEN + body_bytes(w, h);
    if (keep >= 0 && keep < total) total = keep;
    for (int k = 0; k < total; k++) begin
      if (k < HDR_LEN) v = hdr[k];
      else if (fill < 0) v = 8'($urandom_range(0, 255));
      else v = fill[7:0];
      queue_byte((k == 0), v);
      counted_bytes++;
    end
    add_noise(tail);
  endtask

  // Offers one word on in_bus after a random gap and holds it until it is taken.
  // Valid gets at most one assignment per falling edge.
  task automatic send_byte(input logic [7:0] b, input logic sof);
    int unsigned gap;
    gap = pick_gap(quiet_in);
    repeat (gap) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk);
    in_bus.valid         <= 1'b1;
    in_bus.data_byte     <= b;
    in_bus.start_of_file <= sof;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
  endtask

  task automatic send_file_bytes();
    file_byte_t fb;
    while (file_bytes.size() != 0) begin
      fb = file_bytes.pop_front();
      send_byte(fb.data, fb.sof);
    end
  endtask

  // The receiver stalls out_bus at random; now and then it switches to a quiet
  // stretch where it takes every word at once.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_bus.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      out_bus.ready <= 1'b1;
      stall_left    <= pick_gap(quiet_out);
      if ($urandom_range(0, 199) == 0) quiet_out <= !quiet_out;
    end
  end

  // Every word accepted on in_bus is handed to the predictor.
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready)
      sb.note_byte(in_bus.data_byte, in_bus.start_of_file);
  end

  // Every word accepted on out_bus is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      seen_result.result_kind   = out_bus.result_kind;
      seen_result.error_code    = out_bus.error_code;
      seen_result.pixel_color   = out_bus.pixel_color;
      seen_result.pixel_address = out_bus.pixel_address;
      seen_result.image_width   = out_bus.image_width;
      seen_result.image_height  = out_bus.image_height;
      seen_result.last_pixel    = out_bus.last_pixel;
      sb.check_result(seen_result);
    end
  end

  // The watchdog counts cycles with no word moving on either channel.  A
  // prediction that never arrives ends the run here.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] w;
    logic [31:0] h;
    int          r;
    sb = new(MAX_W, MAX_H);
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.data_byte     = '0;
    in_bus.start_of_file = 1'b0;
    out_bus.ready        = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed files.  Bytes ahead of the first start mark must be ignored.
    add_noise(4);
    // Smallest image, every colour bit set, with padding and trailing bytes.
    add_file(1, 1, '0, -1, 3, 8'hFF);
    // Several faults at once: the lowest code wins; later bytes are ignored.
    add_file(4, 1, (8'b1 << ERR_SIGNATURE) | (8'b1 << ERR_COMPRESS), HDR_LEN, 3, -1);
    add_file(3, 2, (8'b1 << ERR_HDR_SIZE) | (8'b1 << ERR_PLANES), HDR_LEN, 0, -1);
    add_file(3, 2, 8'b1 << ERR_COMPRESS, HDR_LEN, 0, -1);
    // A field fault hides a size fault.
    add_file(MAX_W + 1, 2, 8'b1 << ERR_PLANES, -1, 0, -1);
    // A top-down height with its top bit set counts as out of range.
    add_file(2, 32'h8000_0001, '0, -1, 0, -1);
    // Zero width: accepted, but no pixels follow.
    add_file(0, 5, '0, -1, 2, -1);
    // Largest width and largest height, each cut short a few pixels in, so the
    // next start mark lands in the middle of the pixels.
    add_file(MAX_W, 2, '0, HDR_LEN + 12, 0, -1);
    add_file(1, MAX_H, '0, HDR_LEN + 8, 0, -1);
    // A start mark in the middle of the header.
    add_file(5, 3, '0, 20, 0, -1);
    send_file_bytes();

    // Random files, most of them well formed with random content.
    counted_bytes = 0;
    while (counted_bytes < RANDOM_BYTES) begin
      quiet_in = ($urandom_range(0, 4) == 0);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 48) : $urandom_range(1, 7);
      h = $urandom_range(1, 5);
      r = $urandom_range(0, 99);
      if (r < 60) begin
        add_file(w, h, '0, -1, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0, -1);
      end else if (r < 72) begin
        add_file(w, h, 8'($urandom_range(1, 15)) << 1, -1, 0, -1);
      end else if (r < 80) begin
        case ($urandom_range(0, 3))
          0: w = '0;
          1: h = '0;
          2: w = ($urandom_range(0, 1) == 0) ? MAX_W + $urandom_range(1, 3000) : $urandom;
          default: h = {1'b1, 31'($urandom)};
        endcase
        add_file(w, h, '0, -1, 0, -1);
      end else if (r < 92) begin
        add_file(w, h, '0, $urandom_range(1, HDR_LEN + body_bytes(w, h) - 1), 0, -1);
      end else begin
        add_noise($urandom_range(1, 8));
        add_file(w, h, '0, -1, 0, -1);
      end
      send_file_bytes();
    end

    @(negedge clk);
    in_bus.valid <= 1'b0;

    // Let the last results drain, then allow for anything arriving late.
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
